/* hw/rtl/drd_pkg.sv */
// Shared constants, types and helper functions of the detection row decoder.
package drd_pkg;

    // Row layout: four box values, objectness, then the class scores
    localparam int NUM_CLASSES = 80;
    localparam int ROW_LEN     = 5 + NUM_CLASSES;
    localparam int COUNT_W     = 7;
    localparam int CLASS_W     = 7;

    localparam logic [COUNT_W-1:0] ELEM_CENTER_X    = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] ELEM_CENTER_Y    = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] ELEM_BOX_W       = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] ELEM_BOX_H       = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] ELEM_OBJECTNESS  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] ELEM_FIRST_CLASS = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] ELEM_END         = COUNT_W'(ROW_LEN);

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int THRESH_W = 17;
    localparam int SCALE_W  = 16;
    localparam int PIXEL_W  = 16;
    localparam int OUT_DATA_W = 104;

    // Configuration register map
    localparam int CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONF_THRESHOLD  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_SCORE_THRESHOLD = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_X_SCALE         = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_SCALE         = CFG_ADDR_W'(3);

    localparam logic [THRESH_W-1:0] CONF_THRESHOLD_RESET  = THRESH_W'(32768);
    localparam logic [THRESH_W-1:0] SCORE_THRESHOLD_RESET = THRESH_W'(16384);
    localparam logic [SCALE_W-1:0]  X_SCALE_RESET         = SCALE_W'(4096);
    localparam logic [SCALE_W-1:0]  Y_SCALE_RESET         = SCALE_W'(4096);

    // Scaling arithmetic: corner uses 2*center - size, so one more shift bit
    localparam int CORNER_SHIFT  = 29;
    localparam int SIZE_SHIFT    = 28;
    localparam int SPAN_W        = VALUE_W + 2;
    localparam int CORNER_PROD_W = SPAN_W + SCALE_W + 1;
    localparam int CORNER_Q_W    = CORNER_PROD_W - CORNER_SHIFT;
    localparam int SIZE_PROD_W   = VALUE_W + SCALE_W + 1;
    localparam int SIZE_Q_W      = SIZE_PROD_W - SIZE_SHIFT;

    typedef struct packed {
        logic [THRESH_W-1:0] conf_threshold;
        logic [THRESH_W-1:0] score_threshold;
        logic [SCALE_W-1:0]  x_scale;
        logic [SCALE_W-1:0]  y_scale;
    } drd_cfg_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] center_x;
        logic signed [VALUE_W-1:0] center_y;
        logic signed [VALUE_W-1:0] box_w;
        logic signed [VALUE_W-1:0] box_h;
        logic [CLASS_W-1:0]        class_index;
        logic signed [VALUE_W-1:0] class_score;
    } drd_box_t;

    // Clamp a truncated corner quotient to the signed pixel range
    function automatic logic [PIXEL_W-1:0] sat_corner(input logic signed [CORNER_Q_W-1:0] q);
        logic [PIXEL_W-1:0] res;
        if (q > $signed(CORNER_Q_W'(32767))) begin
            res = PIXEL_W'(16'h7FFF);
        end else if (q < -$signed(CORNER_Q_W'(32768))) begin
            res = PIXEL_W'(16'h8000);
        end else begin
            res = q[PIXEL_W-1:0];
        end
        return res;
    endfunction

    // Clamp a size product to the unsigned pixel range; negative gives zero
    function automatic logic [PIXEL_W-1:0] sat_size(input logic signed [SIZE_PROD_W-1:0] p);
        logic [PIXEL_W-1:0] res;
        if (p[SIZE_PROD_W-1]) begin
            res = '0;
        end else if (p[SIZE_PROD_W-1:SIZE_SHIFT+PIXEL_W] != '0) begin
            res = '1;
        end else begin
            res = p[SIZE_SHIFT+PIXEL_W-1:SIZE_SHIFT];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/drd_row_track.sv */
// Input register, per-row element tracking, running argmax and box candidate register.
module drd_row_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [drd_pkg::VALUE_W-1:0]   s_value,
    input  logic                          s_last,
    input  drd_pkg::drd_cfg_t             cfg,
    output logic                          cand_valid,
    input  logic                          cand_ready,
    output drd_pkg::drd_box_t             cand
);

    logic                                 in_valid_reg;
    logic signed [drd_pkg::VALUE_W-1:0]   value_reg;
    logic                                 last_reg;

    logic [drd_pkg::COUNT_W-1:0]          count_reg, count_next;
    logic signed [drd_pkg::VALUE_W-1:0]   cx_reg, cx_next;
    logic signed [drd_pkg::VALUE_W-1:0]   cy_reg, cy_next;
    logic signed [drd_pkg::VALUE_W-1:0]   w_reg, w_next;
    logic signed [drd_pkg::VALUE_W-1:0]   h_reg, h_next;
    logic                                 objok_reg, objok_next;
    logic signed [drd_pkg::VALUE_W-1:0]   best_score_reg, best_score_next;
    logic [drd_pkg::CLASS_W-1:0]          best_class_reg, best_class_next;

    logic                                 cand_valid_reg;
    drd_pkg::drd_box_t                    cand_reg;

    logic                                 slot_free;
    logic                                 fire;
    logic                                 emit;

    // Advance the held beat when the candidate slot is free
    assign slot_free = !cand_valid_reg || cand_ready;
    assign fire      = in_valid_reg && slot_free;
    assign s_ready   = !in_valid_reg || slot_free;

    // Capture the incoming beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            value_reg <= $signed(s_value);
            last_reg  <= s_last;
        end
    end

    // Route the held element by its place in the row
    always_comb begin
        count_next      = count_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        objok_next      = objok_reg;
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        priority if (count_reg == drd_pkg::ELEM_CENTER_X) begin
            cx_next = value_reg;
        end else if (count_reg == drd_pkg::ELEM_CENTER_Y) begin
            cy_next = value_reg;
        end else if (count_reg == drd_pkg::ELEM_BOX_W) begin
            w_next = value_reg;
        end else if (count_reg == drd_pkg::ELEM_BOX_H) begin
            h_next = value_reg;
        end else if (count_reg == drd_pkg::ELEM_OBJECTNESS) begin
            objok_next = value_reg >= $signed({15'd0, cfg.conf_threshold});
        end else if (count_reg < drd_pkg::ELEM_END) begin
            // first class always wins, later ones only when strictly higher
            if (count_reg == drd_pkg::ELEM_FIRST_CLASS || value_reg > best_score_reg) begin
                best_score_next = value_reg;
                best_class_next = count_reg - drd_pkg::ELEM_FIRST_CLASS;
            end
        end else begin
            // past the last class score: ignore
        end
        if (count_reg < drd_pkg::ELEM_END) begin
            count_next = count_reg + 1'b1;
        end
    end

    // Decide the row on its last beat with this beat already folded in
    assign emit = last_reg && (count_reg >= drd_pkg::ELEM_FIRST_CLASS) && objok_next &&
                  (best_score_next > $signed({15'd0, cfg.score_threshold}));

    // Update row state, clear it at row end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            objok_reg      <= 1'b0;
            best_score_reg <= '0;
            best_class_reg <= '0;
        end else if (fire) begin
            if (last_reg) begin
                count_reg      <= '0;
                objok_reg      <= 1'b0;
                best_score_reg <= '0;
                best_class_reg <= '0;
            end else begin
                count_reg      <= count_next;
                objok_reg      <= objok_next;
                best_score_reg <= best_score_next;
                best_class_reg <= best_class_next;
            end
        end
        if (fire) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            w_reg  <= w_next;
            h_reg  <= h_next;
        end
    end

    // Hold the box candidate until the scaler takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_valid_reg <= 1'b0;
        end else if (fire) begin
            cand_valid_reg <= emit;
        end else if (cand_ready) begin
            cand_valid_reg <= 1'b0;
        end
        if (fire && emit) begin
            cand_reg.center_x    <= cx_next;
            cand_reg.center_y    <= cy_next;
            cand_reg.box_w       <= w_next;
            cand_reg.box_h       <= h_next;
            cand_reg.class_index <= best_class_next;
            cand_reg.class_score <= best_score_next;
        end
    end

    assign cand_valid = cand_valid_reg;
    assign cand       = cand_reg;

endmodule

/* hw/rtl/drd_box_scale.sv */
// Scaling of a box candidate to image pixels, with truncation, saturation and output register.
module drd_box_scale (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cand_valid,
    output logic                             cand_ready,
    input  drd_pkg::drd_box_t                cand,
    input  drd_pkg::drd_cfg_t                cfg,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [drd_pkg::OUT_DATA_W-1:0]   m_data
);

    logic signed [drd_pkg::VALUE_W-1:0]       cx, cy, bw, bh;
    logic signed [drd_pkg::SCALE_W:0]         xs, ys;
    logic signed [drd_pkg::SPAN_W-1:0]        span_x, span_y;
    logic signed [drd_pkg::CORNER_PROD_W-1:0] prod_x, prod_y;
    logic signed [drd_pkg::CORNER_PROD_W-1:0] bias_x, bias_y;
    logic signed [drd_pkg::SIZE_PROD_W-1:0]   prod_w, prod_h;
    logic [drd_pkg::PIXEL_W-1:0]              box_x, box_y, box_width, box_height;

    logic                                     out_valid_reg;
    logic [drd_pkg::OUT_DATA_W-1:0]           out_data_reg;

    assign cx = cand.center_x;
    assign cy = cand.center_y;
    assign bw = cand.box_w;
    assign bh = cand.box_h;
    assign xs = $signed({1'b0, cfg.x_scale});
    assign ys = $signed({1'b0, cfg.y_scale});

    // Corner: (2*center - size) * scale, truncated toward zero
    assign span_x = $signed({cx[drd_pkg::VALUE_W-1], cx, 1'b0}) -
                    $signed({{2{bw[drd_pkg::VALUE_W-1]}}, bw});
    assign span_y = $signed({cy[drd_pkg::VALUE_W-1], cy, 1'b0}) -
                    $signed({{2{bh[drd_pkg::VALUE_W-1]}}, bh});
    assign prod_x = span_x * xs;
    assign prod_y = span_y * ys;
    assign bias_x = prod_x + $signed({{(drd_pkg::CORNER_PROD_W-drd_pkg::CORNER_SHIFT){1'b0}},
                                      {drd_pkg::CORNER_SHIFT{prod_x[drd_pkg::CORNER_PROD_W-1]}}});
    assign bias_y = prod_y + $signed({{(drd_pkg::CORNER_PROD_W-drd_pkg::CORNER_SHIFT){1'b0}},
                                      {drd_pkg::CORNER_SHIFT{prod_y[drd_pkg::CORNER_PROD_W-1]}}});
    assign box_x = drd_pkg::sat_corner(
        $signed(bias_x[drd_pkg::CORNER_PROD_W-1:drd_pkg::CORNER_SHIFT]));
    assign box_y = drd_pkg::sat_corner(
        $signed(bias_y[drd_pkg::CORNER_PROD_W-1:drd_pkg::CORNER_SHIFT]));

    // Size: size * scale; a negative product clamps to zero
    assign prod_w     = bw * xs;
    assign prod_h     = bh * ys;
    assign box_width  = drd_pkg::sat_size(prod_w);
    assign box_height = drd_pkg::sat_size(prod_h);

    // Load the result beat when the output is empty or being taken
    assign cand_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cand_ready) begin
            out_valid_reg <= cand_valid;
        end
        if (cand_ready && cand_valid) begin
            out_data_reg <= {1'b0, cand.class_score, cand.class_index,
                             box_height, box_width, box_y, box_x};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* hw/rtl/detection_row_decode_unit.sv */
// Top level of the detection row decoder: configuration registers and stage wiring.
//
// Decodes detector output rows streamed one Q16.16 element per beat (center x, center y,
// width, height, objectness, then the class scores, tlast on the last element of a row).
// One element is accepted every cycle while results drain; a row that passes the
// objectness and score thresholds yields one box beat, carried from its tlast beat through
// the input register, candidate register and output register. The only stall source is
// m_tready: a held result blocks the candidate slot, which in turn holds s_tready low.
// Configuration registers: 0 objectness threshold, 1 score threshold, 2 x scale (Q4.12),
// 3 y scale (Q4.12); other addresses are ignored. Write them only while the block is idle.
module detection_row_decode_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // [31:0] value
    input  logic                               s_tlast,   // row_end
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [drd_pkg::OUT_DATA_W-1:0]     m_tdata,   // [15:0] box_x, [31:16] box_y,
                                                          // [47:32] box_width,
                                                          // [63:48] box_height,
                                                          // [70:64] class_index,
                                                          // [102:71] class_score, [103] 0
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [drd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [drd_pkg::THRESH_W-1:0]       cfg_wdata
);

    drd_pkg::drd_cfg_t cfg_reg;
    logic              cand_valid;
    logic              cand_ready;
    drd_pkg::drd_box_t cand;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conf_threshold  <= drd_pkg::CONF_THRESHOLD_RESET;
            cfg_reg.score_threshold <= drd_pkg::SCORE_THRESHOLD_RESET;
            cfg_reg.x_scale         <= drd_pkg::X_SCALE_RESET;
            cfg_reg.y_scale         <= drd_pkg::Y_SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                drd_pkg::CFG_CONF_THRESHOLD:  cfg_reg.conf_threshold  <= cfg_wdata;
                drd_pkg::CFG_SCORE_THRESHOLD: cfg_reg.score_threshold <= cfg_wdata;
                drd_pkg::CFG_X_SCALE:         cfg_reg.x_scale <= cfg_wdata[drd_pkg::SCALE_W-1:0];
                drd_pkg::CFG_Y_SCALE:         cfg_reg.y_scale <= cfg_wdata[drd_pkg::SCALE_W-1:0];
                default: begin
                    // unmapped address: drop
                end
            endcase
        end
    end

    drd_row_track u_row_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_value    (s_tdata),
        .s_last     (s_tlast),
        .cfg        (cfg_reg),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand)
    );

    drd_box_scale u_box_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand),
        .cfg        (cfg_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata)
    );

endmodule

/* test/detection_row_decode_unit_tb.sv */
// Self-checking testbench for the detection row decoder: random rows, stalls and settings.
`timescale 1ns / 1ps

module detection_row_decode_unit_tb;

    localparam int  ELEMENT_GOAL   = 1900;
    localparam int  PHASE_ELEMENTS = 250;
    localparam int  MAX_PHASES     = 40;
    localparam int  IDLE_LIMIT     = 3000;
    localparam int  REPORT_LIMIT   = 10;
    localparam logic [drd_pkg::CFG_ADDR_W-1:0] CFG_UNMAPPED_LOW  =
        drd_pkg::CFG_Y_SCALE + 1'b1;
    localparam logic [drd_pkg::CFG_ADDR_W-1:0] CFG_UNMAPPED_HIGH = '1;

    // One result beat, box_x in the lowest bits
    typedef struct packed {
        logic [drd_pkg::VALUE_W-1:0] score;
        logic [drd_pkg::CLASS_W-1:0] cls;
        logic [drd_pkg::PIXEL_W-1:0] h;
        logic [drd_pkg::PIXEL_W-1:0] w;
        logic [drd_pkg::PIXEL_W-1:0] y;
        logic [drd_pkg::PIXEL_W-1:0] x;
    } box_beat_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [31:0]                      s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [drd_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [drd_pkg::CFG_ADDR_W-1:0]   cfg_addr;
    logic [drd_pkg::THRESH_W-1:0]     cfg_wdata;

    detection_row_decode_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Row decoder prediction plus the queue of boxes still to arrive
    class box_scoreboard;
        logic [drd_pkg::THRESH_W-1:0]       conf_thr;
        logic [drd_pkg::THRESH_W-1:0]       score_thr;
        logic [drd_pkg::SCALE_W-1:0]        x_scale;
        logic [drd_pkg::SCALE_W-1:0]        y_scale;
        logic [drd_pkg::COUNT_W-1:0]        elem_count;
        logic signed [drd_pkg::VALUE_W-1:0] cx;
        logic signed [drd_pkg::VALUE_W-1:0] cy;
        logic signed [drd_pkg::VALUE_W-1:0] bw;
        logic signed [drd_pkg::VALUE_W-1:0] bh;
        bit                                 obj_ok;
        logic signed [drd_pkg::VALUE_W-1:0] best_score;
        logic [drd_pkg::CLASS_W-1:0]        best_class;
        box_beat_t                          boxes_due[$];
        int                                 predicted;
        int                                 checked;
        int                                 mismatches;

        function new();
            conf_thr   = drd_pkg::CONF_THRESHOLD_RESET;
            score_thr  = drd_pkg::SCORE_THRESHOLD_RESET;
            x_scale    = drd_pkg::X_SCALE_RESET;
            y_scale    = drd_pkg::Y_SCALE_RESET;
            cx         = '0;
            cy         = '0;
            bw         = '0;
            bh         = '0;
            predicted  = 0;
            checked    = 0;
            mismatches = 0;
            clear_row();
        endfunction

        function void clear_row();
            elem_count = '0;
            obj_ok     = 0;
            best_score = '0;
            best_class = '0;
        endfunction

        function void write_reg(logic [drd_pkg::CFG_ADDR_W-1:0] idx,
                                logic [drd_pkg::THRESH_W-1:0] data);
            case (idx)
                drd_pkg::CFG_CONF_THRESHOLD:  conf_thr  = data;
                drd_pkg::CFG_SCORE_THRESHOLD: score_thr = data;
                drd_pkg::CFG_X_SCALE:         x_scale   = data[drd_pkg::SCALE_W-1:0];
                drd_pkg::CFG_Y_SCALE:         y_scale   = data[drd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // Divide by 2^sh, rounding toward zero
        function longint shr_trunc(longint p, int sh);
            if (p < 0) begin
                return -((-p) >>> sh);
            end
            return p >>> sh;
        endfunction

        function logic [drd_pkg::PIXEL_W-1:0] clamp_s16(longint v);
            if (v > 32767) begin
                return 16'h7FFF;
            end
            if (v < -32768) begin
                return 16'h8000;
            end
            return v[drd_pkg::PIXEL_W-1:0];
        endfunction

        function logic [drd_pkg::PIXEL_W-1:0] clamp_u16(longint v);
            if (v > 65535) begin
                return 16'hFFFF;
            end
            if (v < 0) begin
                return '0;
            end
            return v[drd_pkg::PIXEL_W-1:0];
        endfunction

        function void note_element(logic [drd_pkg::VALUE_W-1:0] value, bit last);
            logic signed [drd_pkg::VALUE_W-1:0] v;
            logic [drd_pkg::COUNT_W-1:0]        cls;
            longint                             span_x;
            longint                             span_y;
            longint                             xs;
            longint                             ys;
            box_beat_t                          box;
            v = value;
            // Hold box values, test objectness, track the first highest class
            case (elem_count)
                drd_pkg::ELEM_CENTER_X:   cx = v;
                drd_pkg::ELEM_CENTER_Y:   cy = v;
                drd_pkg::ELEM_BOX_W:      bw = v;
                drd_pkg::ELEM_BOX_H:      bh = v;
                drd_pkg::ELEM_OBJECTNESS: obj_ok = longint'(v) >= longint'(conf_thr);
                default: begin
                    if (elem_count < drd_pkg::ELEM_END) begin
                        cls = elem_count - drd_pkg::ELEM_FIRST_CLASS;
                        if (cls == '0 || v > best_score) begin
                            best_score = v;
                            best_class = cls[drd_pkg::CLASS_W-1:0];
                        end
                    end
                end
            endcase
            if (elem_count < drd_pkg::ELEM_END) begin
                elem_count++;
            end
            if (!last) begin
                return;
            end
            // Decide the row on its last element
            if (elem_count > drd_pkg::ELEM_FIRST_CLASS && obj_ok &&
                longint'(best_score) > longint'(score_thr)) begin
                xs        = longint'(x_scale);
                ys        = longint'(y_scale);
                span_x    = 2 * longint'(cx) - longint'(bw);
                span_y    = 2 * longint'(cy) - longint'(bh);
                box.x     = clamp_s16(shr_trunc(span_x * xs, drd_pkg::CORNER_SHIFT));
                box.y     = clamp_s16(shr_trunc(span_y * ys, drd_pkg::CORNER_SHIFT));
                box.w     = clamp_u16(shr_trunc(longint'(bw) * xs, drd_pkg::SIZE_SHIFT));
                box.h     = clamp_u16(shr_trunc(longint'(bh) * ys, drd_pkg::SIZE_SHIFT));
                box.cls   = best_class;
                box.score = best_score;
                boxes_due = {boxes_due, box};
                predicted++;
            end
            clear_row();
        endfunction

        function string describe(box_beat_t b);
            return $sformatf("x=%0d y=%0d w=%0d h=%0d class=%0d score=%0d",
                             $signed(b.x), $signed(b.y), b.w, b.h, b.cls, $signed(b.score));
        endfunction

        function void check_box(logic [drd_pkg::OUT_DATA_W-1:0] beat);
            box_beat_t got;
            box_beat_t want;
            got = box_beat_t'(beat[$bits(box_beat_t)-1:0]);
            checked++;
            if (boxes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("box with no row pending: got %s", describe(got));
                end
                return;
            end
            want = boxes_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
                got.h !== want.h || got.cls !== want.cls || got.score !== want.score) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("box mismatch: expected %s", describe(want));
                    $display("                   got %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return boxes_due.size();
        endfunction
    endclass

    box_scoreboard  sb;
    logic [31:0]    row_buf[$];
    int             elements_sent;
    int             rows_sent;
    int             settings_used;

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Box coordinates: pixel-range values, extremes and raw noise
    function automatic logic [31:0] box_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            4:       return 32'd0 - 32'($urandom_range(0, 64 << 16));
            default: return 32'($urandom_range(0, 640 << 16));
        endcase
    endfunction

    // Objectness near the threshold, on it and just below it
    function automatic logic [31:0] objectness_value(logic [drd_pkg::THRESH_W-1:0] thr);
        case ($urandom_range(0, 9))
            0:       return 32'(thr);
            1:       return 32'(thr) - 32'd1;
            2:       return $urandom;
            default: return 32'(thr) + 32'($urandom_range(0, 65536));
        endcase
    endfunction

    // Class scores around the score threshold, with ties to the running best
    function automatic logic [31:0] score_value(logic [drd_pkg::THRESH_W-1:0] thr,
                                                logic [31:0] row_best, bit have_best);
        case ($urandom_range(0, 11))
            0:       return have_best ? row_best : 32'(thr);
            1:       return 32'(thr);
            2:       return 32'(thr) + 32'd1;
            3:       return $urandom;
            4:       return 32'd0 - 32'($urandom_range(1, 65536));
            default: return 32'(thr) + 32'($urandom_range(0, 40000)) - 32'd8000;
        endcase
    endfunction

    // Present one element and hold it until accepted; starts and ends at a falling edge
    task automatic push_element(input logic [31:0] value, input bit last, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_element(value, last);
        elements_sent++;
        @(negedge aclk);
    endtask

    task automatic send_row(input bit burst);
        for (int i = 0; i < row_buf.size(); i++) begin
            push_element(row_buf[i], i == row_buf.size() - 1, burst ? 0 : pick_gap());
        end
        rows_sent++;
    endtask

    // Build one row: mostly well formed, some short, long or pure noise
    task automatic random_row();
        int          kind;
        int          len;
        bit          noise;
        bit          have_best;
        logic [31:0] row_best;
        logic [31:0] v;
        kind      = $urandom_range(0, 99);
        noise     = 0;
        have_best = 0;
        row_best  = '0;
        if (kind < 8) begin
            len = $urandom_range(1, 5);
        end else if (kind < 14) begin
            len   = $urandom_range(1, drd_pkg::ROW_LEN + 15);
            noise = 1;
        end else if (kind < 24) begin
            len = drd_pkg::ROW_LEN;
        end else if (kind < 30) begin
            len = drd_pkg::ROW_LEN + $urandom_range(1, 12);
        end else begin
            len = 5 + $urandom_range(1, 12);
        end
        row_buf.delete();
        for (int i = 0; i < len; i++) begin
            if (noise || i >= drd_pkg::ROW_LEN) begin
                v = $urandom;
            end else if (i < 4) begin
                v = box_value();
            end else if (i == 4) begin
                v = objectness_value(sb.conf_thr);
            end else begin
                v = score_value(sb.score_thr, row_best, have_best);
                if (!have_best || $signed(v) > $signed(row_best)) begin
                    row_best  = v;
                    have_best = 1;
                end
            end
            row_buf = {row_buf, v};
        end
        send_row($urandom_range(0, 3) == 0);
    endtask

    task automatic cfg_write(input logic [drd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [drd_pkg::THRESH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Drain the block, then load a new setting
    task automatic apply_settings(input logic [drd_pkg::THRESH_W-1:0] conf,
                                  input logic [drd_pkg::THRESH_W-1:0] score,
                                  input logic [drd_pkg::THRESH_W-1:0] xs,
                                  input logic [drd_pkg::THRESH_W-1:0] ys,
                                  input bit unmapped);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_write(drd_pkg::CFG_CONF_THRESHOLD, conf);
        cfg_write(drd_pkg::CFG_SCORE_THRESHOLD, score);
        cfg_write(drd_pkg::CFG_X_SCALE, xs);
        cfg_write(drd_pkg::CFG_Y_SCALE, ys);
        if (unmapped) begin
            cfg_write(CFG_UNMAPPED_LOW, drd_pkg::THRESH_W'($urandom));
            cfg_write(CFG_UNMAPPED_HIGH, '1);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [drd_pkg::THRESH_W-1:0] random_threshold();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return drd_pkg::THRESH_W'(65536);
            default: return drd_pkg::THRESH_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [drd_pkg::THRESH_W-1:0] random_scale();
        case ($urandom_range(0, 5))
            0:       return drd_pkg::THRESH_W'($urandom);
            1:       return drd_pkg::THRESH_W'($urandom_range(0, 65535));
            default: return drd_pkg::THRESH_W'($urandom_range(2048, 12288));
        endcase
    endfunction

    // Result side: random stalls with ready stretches of varying length
    initial begin
        int n;
        m_tready <= 1'b0;
        @(negedge aclk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (n) @(negedge aclk);
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_box(m_tdata);
        end
    end

    // End the run if no beat moves on any channel for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no beat for %0d cycles, %0d boxes outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("FAILED: results differ");
        $finish;
    end

    // Main stimulus
    initial begin
        int phase;
        int phase_end;
        sb            = new();
        elements_sent = 0;
        rows_sent     = 0;
        settings_used = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows on the reset settings
        // row ends on its first element
        row_buf = '{32'h0140_0000};
        send_row(0);
        // row ends on objectness, before any class score
        row_buf = '{32'h0140_0000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000, 32'h0001_0000};
        send_row(0);
        // objectness exactly on its threshold, one class just above its threshold
        row_buf = '{32'h0140_0000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000,
                    32'h0000_8000, 32'h0000_4001};
        send_row(1);
        // tie between two classes: the first one wins
        row_buf = '{32'h0010_8000, 32'h0020_4000, 32'h0008_0000, 32'h0004_0000,
                    32'h0000_C000, 32'h0000_4E20, 32'h0000_7530, 32'h0000_7530};
        send_row(0);
        // extreme values: saturated corners, negative width, largest score
        row_buf = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h0000_4000, 32'h7FFF_FFFF};
        send_row(0);

        // Extreme settings first, then random ones until enough has run
        phase = 0;
        while (phase < 3 || (elements_sent < ELEMENT_GOAL && phase < MAX_PHASES)) begin
            case (phase)
                0:       apply_settings('0, '0, 17'h0FFFF, 17'h0FFFF, 1);
                1:       apply_settings(17'd65536, 17'd65536, '0, '0, 0);
                2:       apply_settings('1, '1, 17'd1, 17'd1, 0);
                default: apply_settings(random_threshold(), random_threshold(),
                                        random_scale(), random_scale(), phase == 3);
            endcase
            phase_end = elements_sent + PHASE_ELEMENTS;
            while (elements_sent < phase_end) begin
                random_row();
            end
            phase++;
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        $display("Covered %0d row elements in %0d rows under %0d register settings",
                 elements_sent, rows_sent, settings_used + 1);
        $display("Boxes: %0d predicted, %0d received, %0d mismatched, %0d missing",
                 sb.predicted, sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
